FILE: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ffba_pkg
// Shared constants and types for the first-fit block allocator.
// ============================================================================
package ffba_pkg;

    // Pool and table dimensions
    localparam int POOL_BYTES    = 131072;
    localparam int TABLE_ENTRIES = 128;

    // Fixed item field widths
    localparam int OP_W     = 1;
    localparam int SIZE_W   = 18;
    localparam int OFFSET_W = 17;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int START_W = $clog2(POOL_BYTES);
    localparam int NXT_W   = $clog2(POOL_BYTES + 1);
    localparam int SUM_W   = ((NXT_W > SIZE_W) ? NXT_W : SIZE_W) + 1;
    localparam int CMP_W   = (START_W > OFFSET_W) ? START_W : OFFSET_W;

    // Stream packing
    localparam int IN_DATA_W  = ((SIZE_W + OFFSET_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OFFSET_W + 7) / 8) * 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_MEMORY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // One block table entry
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0]  size;
        logic [START_W-1:0] start;
    } t_entry;

endpackage

FILE: rtl/core/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// first_fit_block_allocator
// First-fit pool allocator with a bump pointer over a table in block RAM.
// ============================================================================
//
// Each input item is an allocate or a free request and yields exactly one
// result item. The block table (start, size, free flag per entry) sits in a
// single-port-write, registered-read RAM. A request walks the entries in use
// in order, one RAM read issued per cycle with the compare in the cycle after,
// and stops at the first hit: an allocate takes the first free entry large
// enough (reused whole), a free releases the first allocated entry with the
// matching start. An allocate that finds nothing carves a new entry at the
// bump offset when pool and table have room, else reports out of memory; an
// unmatched free reports not found. A walk reads the entries in use one by one
// through the table RAM read port; a hit ends the walk early. The next item
// can be accepted once its predecessor's result is registered. One item is
// in work at a time; the output register lets the next item in while a
// result waits. The table needs no clearing after reset: only entries below
// the fill count are ever read.
//
// i_s_axis_tuser : [0]     opcode (0 allocate, 1 free)
// i_s_axis_tdata : [17:0]  alloc_size, [34:18] free_offset, rest zero
// o_m_axis_tuser : [1:0]   status
// o_m_axis_tdata : [16:0]  block_offset, rest zero
// ============================================================================
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // alloc_size, free_offset
    input  logic [OP_W-1:0]       i_s_axis_tuser,   // opcode
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // block_offset
    output logic [STATUS_W-1:0]   o_m_axis_tuser    // status
);

    // FSM codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Table RAM
    t_entry             mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    // Control and state
    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_count;      // entries in use
    logic [NXT_W-1:0]    r_next;       // bump offset
    logic [CNT_W-1:0]    r_rd_cnt;     // next entry to read
    logic                r_chk_vld;    // r_rd_data valid this cycle
    logic [IDX_W-1:0]    r_chk_idx;

    // Latched request
    logic [OP_W-1:0]     r_op;
    logic [SIZE_W-1:0]   r_size;
    logic [OFFSET_W-1:0] r_off;

    // Pending result and output register
    logic [STATUS_W-1:0] r_res_status;
    logic [OFFSET_W-1:0] r_res_offset;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [OFFSET_W-1:0] r_out_offset;

    logic                in_acc;
    logic                out_free;
    logic                hit;
    logic                scan_end;
    logic [SUM_W-1:0]    carve_end;
    logic                carve_ok;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_offset);
    assign o_m_axis_tuser  = r_out_status;

    // Read side: one entry per cycle while below the fill count
    assign rd_en   = (r_state == S_SCAN) && (r_rd_cnt < r_count);
    assign rd_addr = r_rd_cnt[IDX_W-1:0];

    // Compare on the registered read data
    always_comb begin
        hit = 1'b0;
        if (r_state == S_SCAN && r_chk_vld) begin
            if (r_op == OP_ALLOC) begin
                hit = r_rd_data.free && (r_rd_data.size >= r_size);
            end else begin
                hit = !r_rd_data.free &&
                      (CMP_W'(r_rd_data.start) == CMP_W'(r_off));
            end
        end
    end

    // Walk exhausted: nothing left to read and nothing in flight
    assign scan_end = (r_state == S_SCAN) && !r_chk_vld && (r_rd_cnt == r_count);

    // Bump carve check
    assign carve_end = SUM_W'(r_next) + SUM_W'(r_size);
    assign carve_ok  = (SUM_W'(r_next) < SUM_W'(POOL_BYTES)) &&
                       (carve_end <= SUM_W'(POOL_BYTES)) &&
                       (r_count < CNT_W'(TABLE_ENTRIES));

    // Write side: flip flag on a hit, or append a carved entry
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_chk_idx;
        wr_data = r_rd_data;
        if (hit) begin
            wr_en        = 1'b1;
            wr_data.free = (r_op == OP_FREE);
        end else if (scan_end && r_op == OP_ALLOC && carve_ok) begin
            wr_en         = 1'b1;
            wr_addr       = r_count[IDX_W-1:0];
            wr_data.free  = 1'b0;
            wr_data.size  = r_size;
            wr_data.start = START_W'(r_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_s_axis_tuser;
            r_size <= i_s_axis_tdata[SIZE_W-1:0];
            r_off  <= i_s_axis_tdata[SIZE_W +: OFFSET_W];
        end
        r_chk_idx <= rd_addr;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_next       <= '0;
            r_rd_cnt     <= '0;
            r_chk_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_res_status <= STAT_ALLOCATED;
            r_res_offset <= '0;
            r_out_status <= STAT_ALLOCATED;
            r_out_offset <= '0;
        end else begin
            r_chk_vld <= rd_en;
            // a reload in S_DONE takes precedence over the drain
            if (r_out_vld && i_m_axis_tready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rd_cnt <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                    end
                    if (hit) begin
                        if (r_op == OP_ALLOC) begin
                            r_res_status <= STAT_ALLOCATED;
                            r_res_offset <= OFFSET_W'(r_rd_data.start);
                        end else begin
                            r_res_status <= STAT_FREED;
                            r_res_offset <= '0;
                        end
                        r_state <= S_DONE;
                    end else if (scan_end) begin
                        if (r_op == OP_FREE) begin
                            r_res_status <= STAT_NOT_FOUND;
                            r_res_offset <= '0;
                        end else if (carve_ok) begin
                            r_res_status <= STAT_ALLOCATED;
                            r_res_offset <= OFFSET_W'(r_next);
                            r_count      <= r_count + CNT_W'(1);
                            r_next       <= NXT_W'(carve_end);
                        end else begin
                            r_res_status <= STAT_NO_MEMORY;
                            r_res_offset <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand the result to the output register once it is free
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_offset <= r_res_offset;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for first_fit_block_allocator.
// ============================================================================
//
// The requests go in on the slave stream. A behavioral copy of the block table
// works out the status and the offset of each request when the request is
// accepted. The expected results wait in a queue, and a monitor checks every
// result that leaves the master stream against the oldest entry.
// The run goes through these steps in order:
//   - hand-picked corner cases: empty table, zero-size entries that share a
//     start, double free, stray offsets, oversized requests and the
//     pool-boundary miss;
//   - random mixed traffic while the table fills up;
//   - the pool end or the table end (picked at random), then the free
//     entries drained until the block reports out of memory;
//   - churn on the exhausted table;
//   - a last stretch with no stalls on either side.
// ============================================================================
module tb;
    import ffba_pkg::*;

    localparam int                  CLK_PERIOD = 12;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
    localparam int                  SIZE_TOP   = POOL_BYTES;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] blk_offset;
    } result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // alloc_size, free_offset
    logic [OP_W-1:0]       i_s_axis_tuser = OP_ALLOC;   // opcode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // block_offset
    logic [STATUS_W-1:0]   o_m_axis_tuser;   // status

    // Shadow block table
    logic [OFFSET_W-1:0] tbl_start [TABLE_ENTRIES];
    logic [SIZE_W-1:0]   tbl_size  [TABLE_ENTRIES];
    bit                  tbl_free  [TABLE_ENTRIES];
    int unsigned         tbl_used = 0;
    int unsigned         bump_offset = 0;

    result_t             pending_results [$];
    logic [STATUS_W-1:0] last_status;
    int                  mismatches = 0;

    // Stall control
    bit idle_on = 1'b1;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_stall = 0;

    first_fit_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Allocator behavior
    // ------------------------------------------------------------------------

    // First free entry large enough wins; else carve at the bump offset.
    function automatic result_t allocate_block(input logic [SIZE_W-1:0] req);
        result_t r;
        r.status     = STAT_NO_MEMORY;
        r.blk_offset = '0;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_free[i] && tbl_size[i] >= req) begin
                tbl_free[i]  = 1'b0;
                r.status     = STAT_ALLOCATED;
                r.blk_offset = tbl_start[i];
                return r;
            end
        end
        // Start must stay inside the pool even for a zero-size carve
        if (bump_offset < POOL_BYTES && bump_offset + req <= POOL_BYTES &&
            tbl_used < TABLE_ENTRIES) begin
            tbl_start[tbl_used] = bump_offset[OFFSET_W-1:0];
            tbl_size[tbl_used]  = req;
            tbl_free[tbl_used]  = 1'b0;
            r.status     = STAT_ALLOCATED;
            r.blk_offset = bump_offset[OFFSET_W-1:0];
            tbl_used++;
            bump_offset += req;
        end
        return r;
    endfunction

    // First allocated entry with that start is released.
    function automatic result_t release_block(input logic [OFFSET_W-1:0] off);
        result_t r;
        r.status     = STAT_NOT_FOUND;
        r.blk_offset = '0;
        for (int i = 0; i < tbl_used; i++) begin
            if (!tbl_free[i] && tbl_start[i] == off) begin
                tbl_free[i] = 1'b1;
                r.status    = STAT_FREED;
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_request(input logic [OP_W-1:0]     op,
                                input logic [SIZE_W-1:0]   sz,
                                input logic [OFFSET_W-1:0] off);
        int      gap;
        result_t r;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 17);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {{(IN_DATA_W - SIZE_W - OFFSET_W){1'b0}}, off, sz};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        r = (op == OP_ALLOC) ? allocate_block(sz) : release_block(off);
        last_status = r.status;
        pending_results.push_back(r);
    endtask

    // Unused field carries random bits so the block must ignore it
    task automatic req_alloc(input logic [SIZE_W-1:0] sz);
        send_request(OP_ALLOC, sz, OFFSET_W'($urandom));
    endtask

    task automatic req_free(input logic [OFFSET_W-1:0] off);
        send_request(OP_FREE, SIZE_W'($urandom_range(0, SIZE_TOP)), off);
    endtask

    // Sizes: zero, near an existing entry, ordinary, or beyond the pool room.
    function automatic logic [SIZE_W-1:0] pick_size(input int cap);
        int          d;
        int unsigned s;
        int unsigned lo;
        d = $urandom_range(0, 99);
        if (d < 10)
            return '0;
        if (d < 30 && tbl_used != 0) begin
            s = tbl_size[$urandom_range(0, tbl_used - 1)];
            if (d < 17 && s != 0)
                s = s - 1;
            else if (d < 24 && s < SIZE_TOP)
                s = s + 1;
            return s[SIZE_W-1:0];
        end
        if (d < 90)
            return SIZE_W'($urandom_range(1, cap));
        lo = POOL_BYTES - bump_offset + 1;
        if (lo > SIZE_TOP)
            lo = SIZE_TOP;
        return SIZE_W'($urandom_range(lo, SIZE_TOP));
    endfunction

    // Mostly starts of entries still held, else stray offsets.
    function automatic logic [OFFSET_W-1:0] pick_free_offset();
        int idx;
        if (tbl_used == 0 || $urandom_range(0, 99) < 15)
            return OFFSET_W'($urandom_range(0, OFFSET_MAX));
        idx = $urandom_range(0, tbl_used - 1);
        for (int t = 0; t < 4 && tbl_free[idx]; t++)
            idx = $urandom_range(0, tbl_used - 1);
        return tbl_start[idx];
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t ERROR %s", $realtime, msg);
    endfunction

    // Random stall bursts on the result stream; none once idle_on drops
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_m_axis_tready <= 1'b1;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_m_axis_tready <= (sink_stall == 0);
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_stall = $urandom_range(1, 17);
            i_m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        result_t want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("unexpected result status %0d offset 0x%05h",
                                       o_m_axis_tuser, o_m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                // padding bits above the offset must read zero
                if (o_m_axis_tuser !== want.status ||
                    o_m_axis_tdata !== OUT_DATA_W'(want.blk_offset)) begin
                    log_mismatch($sformatf(
                        "status exp %0d got %0d, tdata exp 0x%05h got 0x%05h",
                        want.status, o_m_axis_tuser, OUT_DATA_W'(want.blk_offset),
                        o_m_axis_tdata));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_corner_cases();
        src_idle_pct  = 25;
        sink_idle_pct = 5;
        req_free('0);                     // empty table
        req_free(OFFSET_MAX);
        req_alloc('0);                    // zero-size carve at 0
        req_alloc('0);                    // second zero-size entry, same start
        req_free('0);                     // releases the first of the two
        req_alloc(SIZE_W'(5));            // no fit in a zero entry: carve
        req_alloc('0);                    // zero-size takes any free entry
        req_free('0);
        req_free('0);
        req_free('0);
        req_free('0);                     // every entry at 0 already free
        req_alloc(SIZE_W'(SIZE_TOP));     // oversized
        req_alloc(SIZE_W'(POOL_BYTES - bump_offset + 1));   // one past pool end
        req_alloc(SIZE_W'(3));            // reuses the size-5 entry whole
        req_alloc(SIZE_W'(200));
        req_free(OFFSET_W'(5));
        req_free(OFFSET_W'(5));           // double free
        req_alloc(SIZE_W'(200));
        req_free(bump_offset[OFFSET_W-1:0]);   // bump offset is never a start
        req_alloc('0);
    endtask

    task automatic test_mixed_traffic(input int n_items, input int cap);
        for (int k = 0; k < n_items; k++) begin
            // change the stall pattern every 50 items, quiet stretches included
            if (k % 50 == 0) begin
                src_idle_pct  = idle_on ? 25 * $urandom_range(0, 2) : 0;
                sink_idle_pct = idle_on ? 5 * $urandom_range(0, 2) : 0;
            end
            if ($urandom_range(0, 99) < 55)
                req_alloc(pick_size(cap));
            else
                req_free(pick_free_offset());
        end
    endtask

    // Either the pool or the table runs out first, picked at random.
    task automatic test_pool_and_table_limits();
        int unsigned room;
        int          guard;
        if (tbl_used < TABLE_ENTRIES && $urandom_range(0, 1)) begin
            room = POOL_BYTES - bump_offset;
            req_alloc(SIZE_W'(room + 1));   // one byte too many
            req_alloc(SIZE_W'(room));       // exact fit up to the pool end
        end else begin
            for (guard = 0; guard < 3 * TABLE_ENTRIES && tbl_used < TABLE_ENTRIES;
                 guard++)
                req_alloc('0);
        end
        // take every free entry; the next zero-size request has nowhere to go
        last_status = STAT_ALLOCATED;
        for (guard = 0; guard < 2 * TABLE_ENTRIES && last_status != STAT_NO_MEMORY;
             guard++)
            req_alloc('0);
        req_alloc(SIZE_W'(1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        int wait_cycles;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cases();
        test_mixed_traffic(500, 600);
        test_pool_and_table_limits();
        test_mixed_traffic(420, 4000);
        idle_on = 1'b0;
        test_mixed_traffic(160, 4000);

        i_s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 20000 && pending_results.size() != 0;
             wait_cycles++)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);
        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("first_fit_block_allocator verification clean");
        else
            $display("first_fit_block_allocator verification failed");
        $finish;
    end

    // Far beyond the slowest correct run
    initial begin
        #(15_000_000);
        $display("first_fit_block_allocator verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ffba_pkg.sv
rtl/core/first_fit_block_allocator.sv
tb/sv/tb.sv
